/* sv/pxe_pkg.sv */
// ----------------------------------------------------------------------------
// pxe_pkg
// Shared types, constants and helper functions of the prefix expression
// evaluator: number format, symbol codes, state and command structures.
// ----------------------------------------------------------------------------
package pxe_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int VAL_BITS    = 48;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  // Multiplier: the second operand is consumed in chunks, most significant first.
  localparam int MUL_W     = 16;
  localparam int MUL_STEPS = (VAL_BITS + MUL_W - 1) / MUL_W;
  localparam int YPAD_W    = MUL_STEPS * MUL_W;
  localparam int PROD_W    = VAL_BITS + MUL_W;
  localparam int MAG_W     = YPAD_W + VAL_BITS;
  localparam int MCNT_W    = $clog2(MUL_STEPS + 1);

  // Divider: one quotient bit per cycle over the scaled dividend.
  localparam int DVD_W     = VAL_BITS + FRAC_BITS;
  localparam int DCNT_W    = $clog2(DVD_W);

  typedef logic signed [VAL_BITS-1:0] val_t;
  typedef logic [VAL_BITS-1:0]        umag_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_OTHER
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP1,
    S_POP2,
    S_POP3,
    S_START,
    S_EXEC,
    S_PUSH,
    S_TOP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    load_o1;
    logic    load_o2;
    logic    opnd_ok;
    logic    start_mul;
    logic    start_div;
    logic    emit;
    status_t emit_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic unit_done;
    logic div_zero;
    logic out_full;
  } sts_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic umag_t mag_of(input val_t v);
    umag_t u;
    u = umag_t'(v);
    return v[VAL_BITS-1] ? VAL_BITS'(~u + 1'b1) : u;
  endfunction

  // Signed result from sign and magnitude, clamped to the value range.
  function automatic val_t sat_mag(input logic neg, input logic [MAG_W-1:0] m);
    logic [MAG_W-1:0] neg_lim;
    neg_lim = MAG_W'(1) << (VAL_BITS - 1);
    if (neg) begin
      if (m >= neg_lim) return VAL_MIN;
      return val_t'(VAL_BITS'(~m[VAL_BITS-1:0] + 1'b1));
    end
    if (m > neg_lim - 1'b1) return VAL_MAX;
    return val_t'(m[VAL_BITS-1:0]);
  endfunction

endpackage

/* sv/prefix_expression_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_unit
// Evaluates prefix expressions fed rightmost character first, on a stack of
// signed Q32.16 values.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, symbol, last) carries one
// character per transaction. A digit pushes its value; + - * / pop two values
// and push the result; any other character pops two and pushes nothing.
// The character with last set ends the expression: one output transaction
// (out_valid, out_stall, value, status) then carries the top of the stack and
// the first error seen, and the stack is cleared.
// The divider yields one quotient bit per cycle over 64 bits; multiply works by
// three 48x16 partial products. One character is processed at a time.
// A finished result sits in the output register; while out_stall holds it,
// the block keeps accepting characters and only waits before emitting the
// next result. Reset empties the stack and clears the error state; stack
// contents need no clearing.
// ----------------------------------------------------------------------------
module prefix_expression_evaluator_unit
  import pxe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 symbol,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [VAL_BITS-1:0] value,
  output logic [1:0]                 status
);

  cmd_t     cmd;
  sts_t     sts;
  ram_req_t ram;
  val_t     rdata;
  val_t     wdata;
  status_t  status_q;

  assign status = status_q;

  pxe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .ram      (ram)
  );

  pxe_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .symbol    (symbol),
    .last      (last),
    .cmd       (cmd),
    .sts       (sts),
    .rdata     (rdata),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status_q)
  );

  pxe_ram #(
    .WIDTH (VAL_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

endmodule

/* sv/pxe_ram.sv */
// ----------------------------------------------------------------------------
// pxe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pxe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/pxe_mul.sv */
// ----------------------------------------------------------------------------
// pxe_mul
// Saturating fixed-point multiplier. Magnitudes are multiplied chunk by chunk
// with one registered partial product per cycle, accumulated by shift and add.
// ----------------------------------------------------------------------------
module pxe_mul
  import pxe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  val_t a,
  input  val_t b,
  output logic done,
  output val_t result
);

  logic              busy;
  logic              fin;
  logic [MCNT_W-1:0] cnt;
  logic              neg;
  umag_t             x;
  logic [YPAD_W-1:0] ysh;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == MCNT_W'(MUL_STEPS)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= mag_of(a);
      ysh <= YPAD_W'(mag_of(b));
      neg <= a[VAL_BITS-1] ^ b[VAL_BITS-1];
      acc <= '0;
    end else if (busy) begin
      if (cnt < MCNT_W'(MUL_STEPS)) begin
        prod <= x * ysh[YPAD_W-1 -: MUL_W];
        ysh  <= ysh << MUL_W;
      end
      // The product issued in the previous cycle joins the accumulator here.
      if (cnt != '0) begin
        acc <= (acc << MUL_W) + MAG_W'(prod);
      end
    end
    if (fin) begin
      result <= sat_mag(neg, acc >> FRAC_BITS);
    end
  end

endmodule

/* sv/pxe_div.sv */
// ----------------------------------------------------------------------------
// pxe_div
// Saturating fixed-point divider. Restoring radix-2 division of the scaled
// dividend magnitude, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pxe_div
  import pxe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  val_t a,
  input  val_t b,
  output logic done,
  output logic div_zero,
  output val_t result
);

  logic              busy;
  logic              fin;
  logic [DCNT_W-1:0] cnt;
  logic              neg;
  umag_t             y;
  logic [DVD_W-1:0]  dvd;
  umag_t             rem;
  umag_t             quo;
  logic              ovf;
  logic [VAL_BITS:0] trial;
  logic              fits;

  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        cnt <= DCNT_W'(DVD_W - 1);
        if (mag_of(b) == '0) begin
          fin <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y        <= mag_of(b);
      dvd      <= DVD_W'(mag_of(a)) << FRAC_BITS;
      neg      <= a[VAL_BITS-1] ^ b[VAL_BITS-1];
      rem      <= '0;
      quo      <= '0;
      ovf      <= 1'b0;
      div_zero <= (mag_of(b) == '0);
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= fits ? VAL_BITS'(trial - {1'b0, y}) : trial[VAL_BITS-1:0];
      quo <= {quo[VAL_BITS-2:0], fits};
      // Any bit shifted out of the quotient means the result saturates.
      ovf <= ovf | quo[VAL_BITS-1];
    end
    if (fin) begin
      result <= sat_mag(neg, MAG_W'({ovf, quo}));
    end
  end

endmodule

/* sv/pxe_dpath.sv */
// ----------------------------------------------------------------------------
// pxe_dpath
// Datapath: symbol register, operand registers, add/subtract, the multiply
// and divide units, stack write data and the output register.
// ----------------------------------------------------------------------------
module pxe_dpath
  import pxe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  symbol,
  input  logic        last,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  val_t        rdata,
  output val_t        wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output val_t        value,
  output status_t     status
);

  logic [7:0] sym_r;
  logic       last_r;
  val_t       o1;
  val_t       o2;
  op_t        op;
  logic [7:0] dig;
  logic       mul_done;
  logic       div_done;
  logic       div_zero;
  val_t       mul_res;
  val_t       div_res;
  logic signed [VAL_BITS:0] sum_add;
  logic signed [VAL_BITS:0] sum_sub;

  function automatic val_t clamp_sum(input logic signed [VAL_BITS:0] s);
    if (s[VAL_BITS] != s[VAL_BITS-1]) begin
      return s[VAL_BITS] ? VAL_MIN : VAL_MAX;
    end
    return val_t'(s[VAL_BITS-1:0]);
  endfunction

  always_comb begin
    if (sym_r >= CH_ZERO && sym_r <= CH_NINE) begin
      op = OP_DIGIT;
    end else begin
      unique case (sym_r)
        CH_PLUS:  op = OP_ADD;
        CH_MINUS: op = OP_SUB;
        CH_STAR:  op = OP_MUL;
        CH_SLASH: op = OP_DIV;
        default:  op = OP_OTHER;
      endcase
    end
  end

  assign dig     = sym_r - CH_ZERO;
  assign sum_add = {o1[VAL_BITS-1], o1} + {o2[VAL_BITS-1], o2};
  assign sum_sub = {o1[VAL_BITS-1], o1} - {o2[VAL_BITS-1], o2};

  always_comb begin
    case (op)
      OP_DIGIT: wdata = val_t'(VAL_BITS'(dig) << FRAC_BITS);
      OP_ADD:   wdata = clamp_sum(sum_add);
      OP_SUB:   wdata = clamp_sum(sum_sub);
      OP_MUL:   wdata = mul_res;
      OP_DIV:   wdata = div_res;
      default:  wdata = '0;
    endcase
  end

  pxe_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start_mul),
    .a      (o1),
    .b      (o2),
    .done   (mul_done),
    .result (mul_res)
  );

  pxe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .a        (o1),
    .b        (o2),
    .done     (div_done),
    .div_zero (div_zero),
    .result   (div_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sym_r  <= symbol;
      last_r <= last;
    end
    // A pop from an empty stack reads as zero.
    if (cmd.load_o1) begin
      o1 <= cmd.opnd_ok ? rdata : '0;
    end
    if (cmd.load_o2) begin
      o2 <= cmd.opnd_ok ? rdata : '0;
    end
    if (cmd.emit) begin
      value  <= cmd.opnd_ok ? rdata : '0;
      status <= cmd.emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.op        = op;
    sts.last      = last_r;
    sts.unit_done = mul_done | div_done;
    // The divider keeps its zero flag until the next division, so it only
    // counts together with the divider's own done.
    sts.div_zero  = div_zero & div_done;
    sts.out_full  = out_valid;
  end

endmodule

/* sv/pxe_ctrl.sv */
// ----------------------------------------------------------------------------
// pxe_ctrl
// Controller: sequences pops, operations, pushes and the final emit for each
// symbol, and keeps the stack count and the first error of the expression.
// ----------------------------------------------------------------------------
module pxe_ctrl
  import pxe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  sts_t     sts,
  output cmd_t     cmd,
  output ram_req_t ram
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  status_t          err, err_next;
  logic             pop_ok, pop_ok_next;
  logic             top_ok, top_ok_next;
  logic [CNT_W-1:0] count_dec;

  assign count_dec = count - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      err    <= ST_OK;
      pop_ok <= 1'b0;
      top_ok <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      err    <= err_next;
      pop_ok <= pop_ok_next;
      top_ok <= top_ok_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    err_next    = err;
    pop_ok_next = pop_ok;
    top_ok_next = top_ok;
    cmd         = '0;
    ram.we      = 1'b0;
    ram.waddr   = count[ADDR_W-1:0];
    ram.re      = 1'b0;
    ram.raddr   = count_dec[ADDR_W-1:0];
    in_stall    = 1'b1;

    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = (sts.op == OP_DIGIT) ? S_PUSH : S_POP1;
      end
      S_POP1, S_POP2: begin
        // The second pop also captures the first operand.
        if (state == S_POP2) begin
          cmd.load_o1 = 1'b1;
          cmd.opnd_ok = pop_ok;
        end
        if (count == '0) begin
          pop_ok_next = 1'b0;
          if (err == ST_OK) err_next = ST_UNDER;
        end else begin
          pop_ok_next = 1'b1;
          ram.re      = 1'b1;
          count_next  = count_dec;
        end
        state_next = (state == S_POP1) ? S_POP2 : S_POP3;
      end
      S_POP3: begin
        cmd.load_o2 = 1'b1;
        cmd.opnd_ok = pop_ok;
        case (sts.op)
          OP_ADD, OP_SUB: state_next = S_PUSH;
          OP_MUL, OP_DIV: state_next = S_START;
          default:        state_next = sts.last ? S_TOP : S_IDLE;
        endcase
      end
      S_START: begin
        cmd.start_mul = (sts.op == OP_MUL);
        cmd.start_div = (sts.op == OP_DIV);
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        if (sts.unit_done) begin
          if (sts.div_zero && err == ST_OK) err_next = ST_DIVZ;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (count >= CNT_W'(STACK_DEPTH)) begin
          if (err == ST_OK) err_next = ST_OVER;
        end else begin
          ram.we     = 1'b1;
          count_next = count + 1'b1;
        end
        state_next = sts.last ? S_TOP : S_IDLE;
      end
      S_TOP: begin
        if (count == '0) begin
          top_ok_next = 1'b0;
        end else begin
          top_ok_next = 1'b1;
          ram.re      = 1'b1;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit    = 1'b1;
          cmd.opnd_ok = top_ok;
          if (err != ST_OK) begin
            cmd.emit_status = err;
          end else begin
            cmd.emit_status = top_ok ? ST_OK : ST_UNDER;
          end
          count_next = '0;
          err_next   = ST_OK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count exceeds the stack depth");

  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    ram.we |=> count == CNT_W'($past(count) + 1'b1))
    else $error("stack write did not advance the count");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (count == '0) && (err == ST_OK) && (state == S_IDLE))
    else $error("emit did not clear the expression state");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_full)
    else $error("emit while the output register is occupied");
`endif

endmodule
